[design/wfdr_pkg.sv]
// ----------------------------------------------------------------------------
// wfdr_pkg
// Shared constants for the wall dissipation rate pipeline: widths, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package wfdr_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int DATA_WIDTH            = 32;
  localparam int RADICAND_WIDTH        = 64;
  localparam int LANE_COUNT            = 3;
  localparam int WEIGHT_WIDTH          = 48;
  localparam int PASS_WIDTH_DEFAULT    = 1;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INV_CONST = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIM_COUNT = 2'd1;

  localparam logic [DATA_WIDTH-1:0] INV_CONST_RESET = 32'd532815;
  localparam logic [1:0]            DIM_THREE       = 2'd3;
  localparam logic [1:0]            DIM_RESET       = 2'd3;

endpackage

[design/wfdr_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// wfdr_sqrt_cell
// One step of a restoring integer square root, registered, with a side
// payload carried along.
// ----------------------------------------------------------------------------
module wfdr_sqrt_cell #(
  parameter int W      = wfdr_pkg::RADICAND_WIDTH,
  parameter int STEP   = 0,
  parameter int PASS_W = wfdr_pkg::PASS_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      in_rem,
  input  logic [W-1:0]      in_root,
  input  logic [PASS_W-1:0] in_pass,
  output logic              out_valid,
  output logic [W-1:0]      out_rem,
  output logic [W-1:0]      out_root,
  output logic [PASS_W-1:0] out_pass
);

  localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * STEP);

  logic [W-1:0] trial;
  logic [W-1:0] rem_next;
  logic [W-1:0] root_next;

  always_comb begin
    trial = in_root + BIT;
    if (in_rem >= trial) begin
      rem_next  = in_rem - trial;
      root_next = (in_root >> 1) + BIT;
    end else begin
      rem_next  = in_rem;
      root_next = in_root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rem  <= rem_next;
      out_root <= root_next;
      out_pass <= in_pass;
    end
  end

endmodule

[design/wfdr_div_cell.sv]
// ----------------------------------------------------------------------------
// wfdr_div_cell
// One quotient bit of a restoring division on several lanes that share a
// divisor, registered, with a side payload carried along.
// ----------------------------------------------------------------------------
module wfdr_div_cell #(
  parameter int NB     = wfdr_pkg::RADICAND_WIDTH,
  parameter int DW     = wfdr_pkg::DATA_WIDTH,
  parameter int LANES  = wfdr_pkg::LANE_COUNT,
  parameter int PASS_W = wfdr_pkg::PASS_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [DW-1:0]              in_divisor,
  input  logic [LANES-1:0][DW-1:0]   in_rem,
  input  logic [LANES-1:0][NB-1:0]   in_acc,
  input  logic [PASS_W-1:0]          in_pass,
  output logic                       out_valid,
  output logic [DW-1:0]              out_divisor,
  output logic [LANES-1:0][DW-1:0]   out_rem,
  output logic [LANES-1:0][NB-1:0]   out_acc,
  output logic [PASS_W-1:0]          out_pass
);

  logic [LANES-1:0][DW:0]   trial;
  logic [LANES-1:0][DW:0]   diff;
  logic [LANES-1:0]         fits;
  logic [LANES-1:0][DW-1:0] rem_next;
  logic [LANES-1:0][NB-1:0] acc_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l]    = {in_rem[l], in_acc[l][NB-1]};
      diff[l]     = trial[l] - {1'b0, in_divisor};
      fits[l]     = trial[l] >= {1'b0, in_divisor};
      rem_next[l] = fits[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
      acc_next[l] = {in_acc[l][NB-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_divisor <= in_divisor;
      out_rem     <= rem_next;
      out_acc     <= acc_next;
      out_pass    <= in_pass;
    end
  end

endmodule

[design/wall_function_dissipation_rate.sv]
// ----------------------------------------------------------------------------
// wall_function_dissipation_rate
// Wall dissipation rate of a k-omega wall function for one wall integration
// point: area magnitude, wall distance and area-weighted dissipation rate.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is taken every clock while item_stall is
// low. The pipeline includes the cell chains: two 32-cell square roots, a
// (32 + FRACTION_BITS)-cell divider for the unit normal and a 64-cell divider
// for the dissipation rate, one result bit per cell. When the result register
// is held, the pipeline keeps filling until an item reaches its last stage.
// Configuration writes are always taken and must occur only while the pipeline
// is empty.
module wall_function_dissipation_rate #(
  parameter int FRACTION_BITS = wfdr_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic signed [31:0]                   area_x,
  input  logic signed [31:0]                   area_y,
  input  logic signed [31:0]                   area_z,
  input  logic signed [31:0]                   wall_node_x,
  input  logic signed [31:0]                   wall_node_y,
  input  logic signed [31:0]                   wall_node_z,
  input  logic signed [31:0]                   opposing_node_x,
  input  logic signed [31:0]                   opposing_node_y,
  input  logic signed [31:0]                   opposing_node_z,
  input  logic [31:0]                          friction_velocity,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [31:0]                          area_magnitude,
  output logic [wfdr_pkg::WEIGHT_WIDTH-1:0]    weighted_dissipation,
  output logic                                 degenerate_flag,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wfdr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam int DW    = wfdr_pkg::DATA_WIDTH;
  localparam int RW    = wfdr_pkg::RADICAND_WIDTH;
  localparam int LN    = wfdr_pkg::LANE_COUNT;
  localparam int WW    = wfdr_pkg::WEIGHT_WIDTH;
  localparam int SQ_N  = RW / 2;
  localparam int NW    = DW + FRACTION_BITS;
  localparam int OM_N  = RW;

  typedef struct packed {
    logic [LN-1:0][DW-1:0] amag;
    logic [LN-1:0][DW:0]   dmag;
    logic [DW-1:0]         fv;
  } sq1_pass_t;

  typedef struct packed {
    logic [LN-1:0][DW:0] dmag;
    logic [DW-1:0]       fv;
  } div1_pass_t;

  typedef struct packed {
    logic [DW-1:0] m;
    logic          m_zero;
    logic [RW-1:0] pf;
  } sq2_pass_t;

  typedef struct packed {
    logic [DW-1:0] m;
    logic          m_zero;
    logic          d_zero;
  } div2_pass_t;

  localparam int SQ1_W  = $bits(sq1_pass_t);
  localparam int DIV1_W = $bits(div1_pass_t);
  localparam int SQ2_W  = $bits(sq2_pass_t);
  localparam int DIV2_W = $bits(div2_pass_t);

  logic [DW-1:0] inv_const;
  logic [1:0]    dim_count;
  logic          en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_const <= wfdr_pkg::INV_CONST_RESET;
      dim_count <= wfdr_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wfdr_pkg::REG_INV_CONST: inv_const <= cfg_data;
        wfdr_pkg::REG_DIM_COUNT: dim_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic signed [LN-1:0][DW-1:0] area_v, wall_v, opp_v;
  logic [LN-1:0][DW-1:0]        amag_in;
  logic [LN-1:0][DW:0]          diff_in, dmag_in;
  logic                         three_d;

  assign area_v = {area_z, area_y, area_x};
  assign wall_v = {wall_node_z, wall_node_y, wall_node_x};
  assign opp_v  = {opposing_node_z, opposing_node_y, opposing_node_x};
  assign three_d = (dim_count == wfdr_pkg::DIM_THREE);

  always_comb begin
    for (int j = 0; j < LN; j++) begin
      diff_in[j] = {wall_v[j][DW-1], wall_v[j]} - {opp_v[j][DW-1], opp_v[j]};
      amag_in[j] = area_v[j][DW-1] ? (~area_v[j] + 32'd1) : area_v[j];
      dmag_in[j] = diff_in[j][DW] ? (~diff_in[j] + 33'd1) : diff_in[j];
    end
    if (!three_d) begin
      amag_in[LN-1] = '0;
      dmag_in[LN-1] = '0;
    end
  end

  logic                  a_valid, b_valid, c_valid;
  logic [LN-1:0][DW-1:0] amag_a, amag_b, amag_c;
  logic [LN-1:0][DW:0]   dmag_a, dmag_b, dmag_c;
  logic [DW-1:0]         fv_a, fv_b, fv_c;
  logic [LN-1:0][RW-1:0] sq_b;
  logic [RW-1:0]         s_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= item_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
    if (en) begin
      amag_a <= amag_in;
      dmag_a <= dmag_in;
      fv_a   <= friction_velocity;
      for (int j = 0; j < LN; j++) begin
        sq_b[j] <= amag_a[j] * amag_a[j];
      end
      amag_b <= amag_a;
      dmag_b <= dmag_a;
      fv_b   <= fv_a;
      s_c    <= sq_b[0] + sq_b[1] + sq_b[2];
      amag_c <= amag_b;
      dmag_c <= dmag_b;
      fv_c   <= fv_b;
    end
  end

  // area magnitude
  logic              s1_valid [0:SQ_N];
  logic [RW-1:0]     s1_rem   [0:SQ_N];
  logic [RW-1:0]     s1_root  [0:SQ_N];
  logic [SQ1_W-1:0]  s1_pass  [0:SQ_N];
  sq1_pass_t         sq1_in, sq1_out;

  assign sq1_in      = '{amag: amag_c, dmag: dmag_c, fv: fv_c};
  assign s1_valid[0] = c_valid;
  assign s1_rem[0]   = s_c;
  assign s1_root[0]  = '0;
  assign s1_pass[0]  = sq1_in;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt_area
    wfdr_sqrt_cell #(.W(RW), .STEP(k), .PASS_W(SQ1_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(s1_valid[k]), .in_rem(s1_rem[k]), .in_root(s1_root[k]),
      .in_pass(s1_pass[k]),
      .out_valid(s1_valid[k+1]), .out_rem(s1_rem[k+1]), .out_root(s1_root[k+1]),
      .out_pass(s1_pass[k+1])
    );
  end

  assign sq1_out = s1_pass[SQ_N];

  // unit normal
  logic                  d1_valid [0:NW];
  logic [DW-1:0]         d1_div   [0:NW];
  logic [LN-1:0][DW-1:0] d1_rem   [0:NW];
  logic [LN-1:0][NW-1:0] d1_acc   [0:NW];
  logic [DIV1_W-1:0]     d1_pass  [0:NW];
  div1_pass_t            div1_in, div1_out;

  assign div1_in     = '{dmag: sq1_out.dmag, fv: sq1_out.fv};
  assign d1_valid[0] = s1_valid[SQ_N];
  assign d1_div[0]   = s1_root[SQ_N][DW-1:0];
  assign d1_rem[0]   = '0;
  assign d1_pass[0]  = div1_in;

  for (genvar j = 0; j < LN; j++) begin : g_normal_dividend
    assign d1_acc[0][j] = {sq1_out.amag[j], {FRACTION_BITS{1'b0}}};
  end

  for (genvar k = 0; k < NW; k++) begin : g_div_normal
    wfdr_div_cell #(.NB(NW), .DW(DW), .LANES(LN), .PASS_W(DIV1_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(d1_valid[k]), .in_divisor(d1_div[k]), .in_rem(d1_rem[k]),
      .in_acc(d1_acc[k]), .in_pass(d1_pass[k]),
      .out_valid(d1_valid[k+1]), .out_divisor(d1_div[k+1]), .out_rem(d1_rem[k+1]),
      .out_acc(d1_acc[k+1]), .out_pass(d1_pass[k+1])
    );
  end

  assign div1_out = d1_pass[NW];

  // distance components
  logic [LN-1:0][FRACTION_BITS+33:0] prod_in;

  always_comb begin
    for (int j = 0; j < LN; j++) begin
      prod_in[j] = d1_acc[NW][j][FRACTION_BITS:0] * div1_out.dmag[j];
    end
  end

  logic                  e_valid, f_valid, g_valid;
  logic [LN-1:0][30:0]   r_e;
  logic [LN-1:0][61:0]   rsq_f;
  logic [RW-1:0]         t_g, pf_f, pf_g;
  logic [DW-1:0]         m_e, m_f, m_g, fv_e;
  logic                  mz_e, mz_f, mz_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d1_valid[NW];
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
    if (en) begin
      for (int j = 0; j < LN; j++) begin
        r_e[j]   <= prod_in[j][FRACTION_BITS+32:FRACTION_BITS+2];
        rsq_f[j] <= r_e[j] * r_e[j];
      end
      m_e  <= d1_div[NW];
      mz_e <= (d1_div[NW] == '0);
      fv_e <= div1_out.fv;
      pf_f <= fv_e * inv_const;
      m_f  <= m_e;
      mz_f <= mz_e;
      t_g  <= RW'(rsq_f[0]) + RW'(rsq_f[1]) + RW'(rsq_f[2]);
      pf_g <= pf_f;
      m_g  <= m_f;
      mz_g <= mz_f;
    end
  end

  // wall distance
  logic              s2_valid [0:SQ_N];
  logic [RW-1:0]     s2_rem   [0:SQ_N];
  logic [RW-1:0]     s2_root  [0:SQ_N];
  logic [SQ2_W-1:0]  s2_pass  [0:SQ_N];
  sq2_pass_t         sq2_in, sq2_out;

  assign sq2_in      = '{m: m_g, m_zero: mz_g, pf: pf_g};
  assign s2_valid[0] = g_valid;
  assign s2_rem[0]   = t_g;
  assign s2_root[0]  = '0;
  assign s2_pass[0]  = sq2_in;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt_dist
    wfdr_sqrt_cell #(.W(RW), .STEP(k), .PASS_W(SQ2_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(s2_valid[k]), .in_rem(s2_rem[k]), .in_root(s2_root[k]),
      .in_pass(s2_pass[k]),
      .out_valid(s2_valid[k+1]), .out_rem(s2_rem[k+1]), .out_root(s2_root[k+1]),
      .out_pass(s2_pass[k+1])
    );
  end

  assign sq2_out = s2_pass[SQ_N];

  // dissipation rate
  logic              d2_valid [0:OM_N];
  logic [DW-1:0]     d2_div   [0:OM_N];
  logic [0:0][DW-1:0] d2_rem  [0:OM_N];
  logic [0:0][RW-1:0] d2_acc  [0:OM_N];
  logic [DIV2_W-1:0] d2_pass  [0:OM_N];
  div2_pass_t        div2_in, div2_out;

  assign div2_in     = '{m: sq2_out.m, m_zero: sq2_out.m_zero,
                         d_zero: (s2_root[SQ_N][DW-1:0] == '0)};
  assign d2_valid[0] = s2_valid[SQ_N];
  assign d2_div[0]   = s2_root[SQ_N][DW-1:0];
  assign d2_rem[0]   = '0;
  assign d2_acc[0]   = sq2_out.pf;
  assign d2_pass[0]  = div2_in;

  for (genvar k = 0; k < OM_N; k++) begin : g_div_rate
    wfdr_div_cell #(.NB(RW), .DW(DW), .LANES(1), .PASS_W(DIV2_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(d2_valid[k]), .in_divisor(d2_div[k]), .in_rem(d2_rem[k]),
      .in_acc(d2_acc[k]), .in_pass(d2_pass[k]),
      .out_valid(d2_valid[k+1]), .out_divisor(d2_div[k+1]), .out_rem(d2_rem[k+1]),
      .out_acc(d2_acc[k+1]), .out_pass(d2_pass[k+1])
    );
  end

  assign div2_out = d2_pass[OM_N];

  // area weighting
  logic                h_valid, i_valid;
  logic [RW-1:0]       lo_h, hi_h;
  logic [RW+DW-1:0]    full_i;
  logic [DW-1:0]       m_h, m_i;
  logic                deg_h, deg_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      i_valid <= 1'b0;
    end else if (en) begin
      h_valid <= d2_valid[OM_N];
      i_valid <= h_valid;
    end
    if (en) begin
      lo_h   <= d2_acc[OM_N][0][DW-1:0] * div2_out.m;
      hi_h   <= d2_acc[OM_N][0][RW-1:DW] * div2_out.m;
      m_h    <= div2_out.m;
      deg_h  <= div2_out.m_zero || div2_out.d_zero;
      full_i <= {hi_h, {DW{1'b0}}} + {{DW{1'b0}}, lo_h};
      m_i    <= m_h;
      deg_i  <= deg_h;
    end
  end

  logic          saturate;
  logic [WW-1:0] weighted_next;

  always_comb begin
    saturate = (full_i[RW+DW-1:RW] != '0) || ((full_i >> (WW + FRACTION_BITS)) != '0);
    if (deg_i) begin
      weighted_next = '0;
    end else if (saturate) begin
      weighted_next = '1;
    end else begin
      weighted_next = full_i[WW+FRACTION_BITS-1:FRACTION_BITS];
    end
  end

  assign en         = !(i_valid && result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!(result_valid && result_stall)) begin
      result_valid <= i_valid;
    end
    if (!(result_valid && result_stall)) begin
      area_magnitude       <= m_i;
      weighted_dissipation <= weighted_next;
      degenerate_flag      <= deg_i;
    end
  end

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate_flag |-> weighted_dissipation == '0)
    else $error("degenerate result carries a nonzero dissipation");

  a_zero_area_flagged: assert property (@(posedge clk) disable iff (rst)
    result_valid && area_magnitude == '0 |-> degenerate_flag)
    else $error("zero area without degenerate flag");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> i_valid && result_valid && result_stall)
    else $error("input stalled while pipeline can advance");

  a_blocked_hold: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> $stable(full_i) && i_valid)
    else $error("last stage changed while pipeline was blocked");

endmodule

[dv/wall_function_dissipation_rate_tb.sv]
// ----------------------------------------------------------------------------
// wall_function_dissipation_rate_tb
// Self-checking bench for the wall dissipation rate pipeline. Directed corner
// transactions and random transactions are driven through a valid/stall port
// with random gaps and output stalls, across several register settings. Each
// result is compared field by field with a predicted value queue.
// ----------------------------------------------------------------------------
module wall_function_dissipation_rate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = wfdr_pkg::FRACTION_BITS_DEFAULT;
  localparam int LATENCY = 169 + FB;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] ax, ay, az, wx, wy, wz, ox, oy, oz, fv;
  } point_t;

  typedef struct packed {
    logic [31:0] amag;
    logic [47:0] wdiss;
    logic        degen;
  } rate_t;

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  logic signed [31:0] area_x, area_y, area_z, wall_node_x, wall_node_y, wall_node_z;
  logic signed [31:0] opposing_node_x, opposing_node_y, opposing_node_z;
  logic [31:0] friction_velocity, area_magnitude, cfg_data;
  logic [47:0] weighted_dissipation;
  logic degenerate_flag, cfg_valid, cfg_ready;
  logic [wfdr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;

  wall_function_dissipation_rate i_dut (.*);

  point_t pending_points[$];
  rate_t  expected_rates[$];
  logic [31:0] inv_const;
  logic [1:0]  dim_count;
  int  error_count;
  int  idle_cycles;
  int  hold_off;
  bit  in_accepted;
  int  send_wait, recv_wait;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] span(input logic [31:0] a, input logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return d < 0 ? -d : d;
  endfunction

  function automatic rate_t predict_rate(input point_t p);
    rate_t r;
    logic [63:0] am[3], dm[3], s, m, t, d, n, q, omega, w;
    logic [31:0] ac[3], wc[3], oc[3];
    int dims;
    dims = (dim_count == wfdr_pkg::DIM_THREE) ? 3 : 2;
    ac = '{p.ax, p.ay, p.az};
    wc = '{p.wx, p.wy, p.wz};
    oc = '{p.ox, p.oy, p.oz};
    s = 0;
    t = 0;
    for (int j = 0; j < 3; j++) begin
      am[j] = span(ac[j], 32'd0);
      dm[j] = span(wc[j], oc[j]);
    end
    for (int j = 0; j < dims; j++) s += am[j] * am[j];
    m = floor_sqrt(s);
    r.amag = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
    r.wdiss = 0;
    r.degen = 1;
    if (m == 0) begin
      r.amag = 0;
      return r;
    end
    for (int j = 0; j < dims; j++) begin
      n = (am[j] << FB) / m;
      q = (n * dm[j]) >> (FB + 2);
      t += q * q;
    end
    d = floor_sqrt(t);
    if (d == 0) return r;
    omega = (64'(p.fv) * 64'(inv_const)) / d;
    if (omega != 0 && m > 64'hFFFF_FFFF_FFFF_FFFF / omega) w = 64'hFFFF_FFFF_FFFF;
    else w = (omega * m) >> FB;
    if (w > 64'hFFFF_FFFF_FFFF) w = 64'hFFFF_FFFF_FFFF;
    r.wdiss = w[47:0];
    r.degen = 0;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
      3: return {$urandom()} >>> $urandom_range(0, 31);
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed(16'($urandom()))) <<< 8;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
    p.wx = rand_coord(); p.wy = rand_coord(); p.wz = rand_coord();
    p.ox = rand_coord(); p.oy = rand_coord(); p.oz = rand_coord();
    if ($urandom_range(0, 9) == 0) begin
      p.ox = p.wx; p.oy = p.wy; p.oz = p.wz;
    end
    if ($urandom_range(0, 15) == 0) begin
      p.ax = 0; p.ay = 0;
    end
    p.fv = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000);
    return p;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 0;
      send_wait <= 0;
    end else if (in_accepted) begin
      pending_points.pop_front();
      if (pending_points.size() > 0 && $urandom_range(0, 3) == 0 && send_wait == 0) begin
        item_valid <= 1;
        {area_x, area_y, area_z, wall_node_x, wall_node_y, wall_node_z,
         opposing_node_x, opposing_node_y, opposing_node_z, friction_velocity}
          <= pending_points[0];
      end else begin
        item_valid <= 0;
        send_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
    end else if (!item_valid) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_points.size() > 0) begin
        item_valid <= 1;
        {area_x, area_y, area_z, wall_node_x, wall_node_y, wall_node_z,
         opposing_node_x, opposing_node_y, opposing_node_z, friction_velocity}
          <= pending_points[0];
      end
    end
  end

  always @(posedge clk) begin
    in_accepted <= !rst && item_valid && !item_stall;
    if (!rst && item_valid && !item_stall) begin
      expected_rates.push_back(predict_rate({area_x, area_y, area_z, wall_node_x,
        wall_node_y, wall_node_z, opposing_node_x, opposing_node_y, opposing_node_z,
        friction_velocity}));
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 0;
      recv_wait <= 0;
    end else if (hold_off > 0) begin
      result_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (recv_wait > 0) begin
      result_stall <= 1;
      recv_wait <= recv_wait - 1;
    end else begin
      result_stall <= 0;
      if (result_valid && !result_stall && $urandom_range(0, 3) == 0)
        recv_wait <= $urandom_range(0, 16);
    end
  end

  always @(posedge clk) begin
    rate_t exp_r;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (result_valid && !result_stall) begin
        if (expected_rates.size() == 0) begin
          $error("unexpected result transaction");
          error_count++;
        end else begin
          exp_r = expected_rates.pop_front();
          if (area_magnitude !== exp_r.amag) begin
            $error("area_magnitude expected %0h actual %0h", exp_r.amag, area_magnitude);
            error_count++;
          end
          if (weighted_dissipation !== exp_r.wdiss) begin
            $error("weighted_dissipation expected %0h actual %0h", exp_r.wdiss,
                   weighted_dissipation);
            error_count++;
          end
          if (degenerate_flag !== exp_r.degen) begin
            $error("degenerate_flag expected %0h actual %0h", exp_r.degen,
                   degenerate_flag);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [wfdr_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == wfdr_pkg::REG_INV_CONST) inv_const = val;
    else if (idx == wfdr_pkg::REG_DIM_COUNT) dim_count = val[1:0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_rates.size() > 0 || item_valid)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    point_t p;
    for (int i = 0; i < count; i++) begin
      p = rand_point();
      pending_points.push_back(p);
    end
    while (pending_points.size() > 0) @(posedge clk);
    drain();
  endtask

  initial begin
    point_t p;
    logic [31:0] ext[4];
    rst = 1;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    item_valid = 0; result_stall = 0;
    {area_x, area_y, area_z, wall_node_x, wall_node_y, wall_node_z,
     opposing_node_x, opposing_node_y, opposing_node_z, friction_velocity} = '0;
    error_count = 0; hold_off = 0;
    inv_const = wfdr_pkg::INV_CONST_RESET;
    dim_count = wfdr_pkg::DIM_RESET;
    repeat (10) @(posedge clk);
    rst <= 0;
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    p = '0;
    pending_points.push_back(p);
    p.ax = 32'h0001_0000; p.wx = 32'h0004_0000; p.fv = 32'h0001_0000;
    pending_points.push_back(p);
    p.wx = 0;
    pending_points.push_back(p);
    for (int i = 0; i < 4; i++) begin
      p.ax = ext[i]; p.ay = ext[3 - i]; p.az = ext[(i + 1) % 4];
      p.wx = ext[(i + 2) % 4]; p.wy = ext[i]; p.wz = ext[3 - i];
      p.ox = ext[3 - i]; p.oy = ext[(i + 1) % 4]; p.oz = ext[i];
      p.fv = ext[i];
      pending_points.push_back(p);
    end
    p = '0;
    p.az = 32'h0010_0000; p.wz = 32'h0100_0000; p.fv = 32'hFFFF_FFFF;
    pending_points.push_back(p);
    p.ax = 32'h7FFF_FFFF; p.ay = 32'h8000_0000; p.az = 32'h8000_0000;
    p.wx = 32'h7FFF_FFFF; p.ox = 32'h8000_0000;
    p.wy = 32'h7FFF_FFFF; p.oy = 32'h8000_0000;
    pending_points.push_back(p);
    drain();
    hold_off = 400;
    run_phase(450);
    write_reg(wfdr_pkg::REG_DIM_COUNT, 32'd2);
    write_reg(wfdr_pkg::REG_INV_CONST, 32'hFFFF_FFFF);
    p = '0;
    p.az = 32'h0010_0000; p.wz = 32'h0100_0000; p.fv = 32'h0001_0000;
    pending_points.push_back(p);
    p.ax = 32'h7FFF_FFFF; p.ay = 32'h8000_0000; p.wx = 32'h7FFF_FFFF;
    p.ox = 32'h8000_0000; p.fv = 32'hFFFF_FFFF;
    pending_points.push_back(p);
    run_phase(350);
    write_reg(wfdr_pkg::REG_DIM_COUNT, 32'd0);
    write_reg(wfdr_pkg::REG_INV_CONST, 32'd0);
    run_phase(200);
    write_reg(wfdr_pkg::REG_DIM_COUNT, 32'd1);
    write_reg(wfdr_pkg::REG_INV_CONST, $urandom());
    run_phase(250);
    write_reg(wfdr_pkg::REG_DIM_COUNT, 32'd3);
    write_reg(wfdr_pkg::REG_INV_CONST, 32'd1);
    run_phase(250);
    write_reg(wfdr_pkg::REG_INV_CONST, wfdr_pkg::INV_CONST_RESET);
    run_phase(330);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[files.f]
design/wfdr_pkg.sv
design/wfdr_sqrt_cell.sv
design/wfdr_div_cell.sv
design/wall_function_dissipation_rate.sv
dv/wall_function_dissipation_rate_tb.sv
